FILE: hdl/terrain_slope_shading_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef TERRAIN_SLOPE_SHADING_MACROS_SVH
`define TERRAIN_SLOPE_SHADING_MACROS_SVH

// implication checked on every clock edge outside reset
`define TSS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/tss_pkg.sv
// Package for the terrain slope shading block: widths, constants, stage types.
// No dependencies.
package tss_pkg;

    localparam int HW      = 12;  // height width
    localparam int LW      = 10;  // light component width
    localparam int GW      = 13;  // gradient width
    localparam int SQW     = 26;  // squared gradient sum plus 4096
    localparam int RW      = 13;  // square root width
    localparam int NW      = 25;  // numerator width
    localparam int QW      = 20;  // quotient width (signed)
    localparam int SHW     = 7;   // shade width
    localparam int DIV_STEPS = 19; // quotient bits for |num| < 2^25, den >= 64

    localparam logic [SQW-1:0] BIAS_SQ = SQW'(64 * 64);

    localparam int CFG_SHADE_MODE = 0;
    localparam int CFG_LIGHT_X    = 1;
    localparam int CFG_LIGHT_Y    = 2;
    localparam int CFG_LIGHT_Z    = 3;

    localparam logic signed [LW-1:0] LIGHT_X_RST = -10'sd106;
    localparam logic signed [LW-1:0] LIGHT_Y_RST = 10'sd99;
    localparam logic signed [LW-1:0] LIGHT_Z_RST = 10'sd213;

    typedef struct packed {
        logic                   mode;
        logic signed [NW-1:0]   num;
        logic        [SQW-1:0]  sq;
    } front_t;

endpackage

FILE: hdl/terrain_slope_shading.sv
// Top level of the terrain slope shading block: config registers and pipeline.
// Depends on tss_pkg, tss_front, tss_sqrt, tss_div.
//
// Usage: heights of the four neighbours enter on the input channel
// (in_valid / in_stall), one word per clock unless stalled. Each word yields one shade word
// on the output channel (out_valid / out_stall).
// Pipeline from the accept edge to the output register: two front-end stages
// (products, sums), thirteen square-root stages (one root bit each), nineteen
// divider stages (one quotient bit each), one output stage.
// Throughput is one word per clock; the pipeline moves as a whole whenever
// the output register is empty or being taken.
// When the receiver stalls, the whole pipeline holds and in_stall is raised
// unless the output slot is free; nothing is lost or repeated.
// Reset clears all valid bits and loads the light vector and shade_mode to
// their defaults. Configuration writes take effect on the next word and
// should only be made while the pipeline is empty.
module terrain_slope_shading (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [tss_pkg::LW-1:0]         cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [tss_pkg::HW-1:0]  height_east,
    input  logic signed [tss_pkg::HW-1:0]  height_west,
    input  logic signed [tss_pkg::HW-1:0]  height_south,
    input  logic signed [tss_pkg::HW-1:0]  height_north,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [tss_pkg::SHW-1:0]        shade
);
    logic                          mode_reg;
    logic signed [tss_pkg::LW-1:0] lx_reg, ly_reg, lz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            lx_reg   <= tss_pkg::LIGHT_X_RST;
            ly_reg   <= tss_pkg::LIGHT_Y_RST;
            lz_reg   <= tss_pkg::LIGHT_Z_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                2'(tss_pkg::CFG_SHADE_MODE): mode_reg <= cfg_data[0];
                2'(tss_pkg::CFG_LIGHT_X):    lx_reg   <= cfg_data;
                2'(tss_pkg::CFG_LIGHT_Y):    ly_reg   <= cfg_data;
                2'(tss_pkg::CFG_LIGHT_Z):    lz_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    logic adv;
    // whole pipeline moves when the output word is absent or taken
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    logic                            f_vld;
    tss_pkg::front_t                 f_data;
    logic                            s_vld, s_mode;
    logic signed [tss_pkg::NW-1:0]   s_num;
    logic        [tss_pkg::RW-1:0]   s_root;

    tss_front u_front (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(in_valid),
        .he(height_east), .hw(height_west), .hs(height_south), .hn(height_north),
        .mode(mode_reg), .lx(lx_reg), .ly(ly_reg), .lz(lz_reg),
        .out_vld(f_vld), .out_data(f_data)
    );

    tss_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(f_vld), .in_data(f_data),
        .out_vld(s_vld), .out_mode(s_mode), .out_num(s_num), .out_root(s_root)
    );

    tss_div u_div (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(s_vld), .in_mode(s_mode),
        .in_num(s_num), .in_den(s_root), .out_vld(out_valid), .out_shade(shade)
    );
endmodule

FILE: hdl/tss_front.sv
// Front end: gradient, numerator products and squared magnitude, two stages.
// Depends on tss_pkg.
module tss_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic                           in_vld,
    input  logic signed [tss_pkg::HW-1:0]  he,
    input  logic signed [tss_pkg::HW-1:0]  hw,
    input  logic signed [tss_pkg::HW-1:0]  hs,
    input  logic signed [tss_pkg::HW-1:0]  hn,
    input  logic                           mode,
    input  logic signed [tss_pkg::LW-1:0]  lx,
    input  logic signed [tss_pkg::LW-1:0]  ly,
    input  logic signed [tss_pkg::LW-1:0]  lz,
    output logic                           out_vld,
    output tss_pkg::front_t                out_data
);
    logic                          v1_reg, v2_reg;
    logic                          m1_reg;
    logic signed [tss_pkg::NW-1:0] px_reg, py_reg, pz_reg;
    logic        [tss_pkg::SQW-1:0] sx_reg, sy_reg;
    tss_pkg::front_t               d2_reg;

    logic signed [tss_pkg::GW-1:0] gx, gy;

    always_comb
    begin
        if (!mode)
        begin
            gx = tss_pkg::GW'(hs) - tss_pkg::GW'(hn);
            gy = tss_pkg::GW'(he) - tss_pkg::GW'(hw);
        end
        else
        begin
            gx = tss_pkg::GW'(he) - tss_pkg::GW'(hw);
            gy = tss_pkg::GW'(hn) - tss_pkg::GW'(hs);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_reg <= mode;
            px_reg <= tss_pkg::NW'(gx * lx);
            py_reg <= tss_pkg::NW'(gy * ly);
            pz_reg <= tss_pkg::NW'(lz) <<< 6;
            sx_reg <= tss_pkg::SQW'(gx * gx);
            sy_reg <= tss_pkg::SQW'(gy * gy);
            d2_reg.mode <= m1_reg;
            d2_reg.num  <= px_reg + py_reg + pz_reg;
            d2_reg.sq   <= sx_reg + sy_reg + tss_pkg::BIAS_SQ;
        end
    end

    assign out_vld  = v2_reg;
    assign out_data = d2_reg;
endmodule

FILE: hdl/tss_sqrt.sv
// Pipelined integer square root, one result bit per stage, plus carried payload.
// Depends on tss_pkg.
module tss_sqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic                           in_vld,
    input  tss_pkg::front_t                in_data,
    output logic                           out_vld,
    output logic                           out_mode,
    output logic signed [tss_pkg::NW-1:0]  out_num,
    output logic        [tss_pkg::RW-1:0]  out_root
);
    localparam int N = tss_pkg::RW;

    logic [N:0]                       v_reg;
    logic [N:0]                       m_reg;
    logic signed [tss_pkg::NW-1:0]    num_reg [N+1];
    logic [tss_pkg::SQW-1:0]          rem_reg [N+1];
    logic [tss_pkg::RW-1:0]           root_reg [N+1];

    assign v_reg[0]    = in_vld;
    assign m_reg[0]    = in_data.mode;
    assign num_reg[0]  = in_data.num;
    assign rem_reg[0]  = in_data.sq;
    assign root_reg[0] = '0;

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        localparam int B = N - 1 - i;
        logic [tss_pkg::SQW+1:0] trial;
        logic                    fit;
        assign trial = ({2'b00, tss_pkg::SQW'(root_reg[i])} << (B + 1))
                     + ((tss_pkg::SQW+2)'(1) << (2 * B));
        assign fit   = {2'b00, rem_reg[i]} >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (adv)
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                m_reg[i+1]   <= m_reg[i];
                num_reg[i+1] <= num_reg[i];
                rem_reg[i+1] <= fit ? tss_pkg::SQW'({2'b00, rem_reg[i]} - trial) : rem_reg[i];
                root_reg[i+1] <= root_reg[i] | (fit ? tss_pkg::RW'(1) << B : '0);
            end
        end
    end

    assign out_vld  = v_reg[N];
    assign out_mode = m_reg[N];
    assign out_num  = num_reg[N];
    assign out_root = root_reg[N];
endmodule

FILE: hdl/tss_div.sv
// Pipelined restoring divider on magnitudes, then shift, offset, clamp, output.
// Depends on tss_pkg.
module tss_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic                           in_vld,
    input  logic                           in_mode,
    input  logic signed [tss_pkg::NW-1:0]  in_num,
    input  logic        [tss_pkg::RW-1:0]  in_den,
    output logic                           out_vld,
    output logic        [tss_pkg::SHW-1:0] out_shade
);
    localparam int N  = tss_pkg::DIV_STEPS;
    localparam int MW = tss_pkg::NW - 1;   // magnitude bits needed

    logic [N:0]            v_reg, m_reg, neg_reg;
    logic [MW-1:0]         dd_reg  [N+1];
    logic [tss_pkg::RW-1:0] den_reg [N+1];
    logic [tss_pkg::RW:0]  rem_reg [N+1];
    logic [N-1:0]          q_reg   [N+1];

    logic [tss_pkg::NW-1:0] mag;
    assign mag = in_num[tss_pkg::NW-1] ? tss_pkg::NW'(-in_num) : tss_pkg::NW'(in_num);

    assign v_reg[0]   = in_vld;
    assign m_reg[0]   = in_mode;
    assign neg_reg[0] = in_num[tss_pkg::NW-1];
    assign dd_reg[0]  = mag[MW-1:0];
    assign den_reg[0] = in_den;
    // top bits above the quotient window start as the partial remainder
    assign rem_reg[0] = (tss_pkg::RW+1)'(mag[MW-1:N]);
    assign q_reg[0]   = '0;

    for (genvar i = 0; i < N; i++)
    begin : g_step
        logic [tss_pkg::RW+1:0] sh;
        logic [tss_pkg::RW+1:0] diff;
        assign sh   = {rem_reg[i], dd_reg[i][N-1-i]};
        assign diff = sh - (tss_pkg::RW+2)'(den_reg[i]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (adv)
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                m_reg[i+1]   <= m_reg[i];
                neg_reg[i+1] <= neg_reg[i];
                dd_reg[i+1]  <= dd_reg[i];
                den_reg[i+1] <= den_reg[i];
                if (!diff[tss_pkg::RW+1])
                begin
                    rem_reg[i+1] <= diff[tss_pkg::RW:0];
                    q_reg[i+1]   <= {q_reg[i][N-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i+1] <= sh[tss_pkg::RW:0];
                    q_reg[i+1]   <= {q_reg[i][N-2:0], 1'b0};
                end
            end
        end
    end

    // final stage: sign, floor shift, offset, clamp
    logic signed [tss_pkg::QW-1:0] q;
    logic signed [tss_pkg::QW-1:0] lig;
    logic        [tss_pkg::SHW-1:0] shade_next;
    logic        [tss_pkg::SHW-1:0] shade_reg;
    logic                           vo_reg;

    always_comb
    begin
        q = neg_reg[N] ? -tss_pkg::QW'(q_reg[N]) : tss_pkg::QW'(q_reg[N]);
        if (!m_reg[N])
        begin
            lig = tss_pkg::QW'(16) + (q >>> 4);
            if (lig < 2) lig = tss_pkg::QW'(2);
            if (lig > 31) lig = tss_pkg::QW'(31);
            shade_next = tss_pkg::SHW'(tss_pkg::QW'(32) - lig);
        end
        else
        begin
            lig = tss_pkg::QW'(64) + (q >>> 2);
            if (lig < 8) lig = tss_pkg::QW'(8);
            if (lig > 124) lig = tss_pkg::QW'(124);
            shade_next = tss_pkg::SHW'(tss_pkg::QW'(128) - lig);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (adv)
            vo_reg <= v_reg[N];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            shade_reg <= shade_next;
    end

    assign out_vld   = vo_reg;
    assign out_shade = shade_reg;
endmodule

FILE: hdl/tss_checker.sv
// Port-level checker for terrain_slope_shading, bound to the top level.
// Depends on terrain_slope_shading_macros.svh.
`include "terrain_slope_shading_macros.svh"
module tss_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [6:0] shade
);
    `TSS_ASSERT_IMPL(a_shade_range, clk, rst_n, out_valid, (shade >= 7'd1 && shade <= 7'd120), "shade out of range")
    `TSS_ASSERT_IMPL(a_stall_only_when_full, clk, rst_n, in_stall, (out_valid && out_stall), "input stalled with free output")
    `TSS_ASSERT_NEXT(a_out_hold, clk, rst_n, (out_valid && out_stall), (out_valid && $stable(shade)), "stalled word changed")
endmodule

bind terrain_slope_shading tss_checker u_tss_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .shade(shade)
);
